>>> design/bdpm_pkg.sv
// Shared types and constants for the bidirectional typed pointer map.
// Used by the slot compare unit and the top level; depends on nothing else.
package bdpm_pkg;

    localparam int ENTRIES  = 64;
    localparam int PTR_BITS = 48;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int SEQ_W    = IDX_W + 1;
    localparam int AGE_W    = IDX_W;
    localparam int KIND_W   = 4;
    localparam int CMD_W    = 4;
    localparam int CNT_W    = 31;
    localparam int OCNT_W   = 32;
    localparam int STAT_W   = 2;

    localparam logic [SEQ_W-1:0] SLOT_END = SEQ_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [CMD_W-1:0] CMD_ADD         = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DEL         = 4'd1;
    localparam logic [CMD_W-1:0] CMD_FIND        = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_REV     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_FIND_REV    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_GET_CNT     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SET_CNT     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_GET_CNT_REV = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SET_CNT_REV = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KIND_W-1:0]   entry_kind;
        logic [PTR_BITS-1:0] key_ptr;
        logic [PTR_BITS-1:0] data_ptr;
        logic [CNT_W-1:0]    new_count;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [PTR_BITS-1:0]      found_key;
        logic [PTR_BITS-1:0]      found_data;
        logic signed [OCNT_W-1:0] found_count;
    } rsp_t;

    typedef struct packed {
        logic [PTR_BITS-1:0] key;
        logic [PTR_BITS-1:0] data;
        logic [KIND_W-1:0]   kind;
        logic [CNT_W-1:0]    count;
        logic [AGE_W-1:0]    age;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic match;
        logic younger;
        logic older;
    } unit_res_t;

endpackage

>>> design/bdpm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Holds the slot table of the pointer map; no dependencies.
module bdpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/bdpm_unit.sv
// Shared slot compare unit: pointer/type match, age ordering and age step.
// Used by the sequencer in both the search and the age update passes; needs bdpm_pkg.
module bdpm_unit
    import bdpm_pkg::*;
(
    input  slot_t               entry,
    input  logic                reverse,
    input  logic [PTR_BITS-1:0] ptr,
    input  logic [KIND_W-1:0]   kind,
    input  logic [AGE_W-1:0]    ref_age,
    input  logic                age_dec,
    output unit_res_t           res,
    output logic [AGE_W-1:0]    age_next
);

    logic [PTR_BITS-1:0] slot_ptr;

    assign slot_ptr    = reverse ? entry.data : entry.key;
    assign res.match   = (slot_ptr == ptr) && (entry.kind == kind);
    assign res.younger = entry.age < ref_age;
    assign res.older   = entry.age > ref_age;
    assign age_next    = age_dec ? (entry.age - AGE_W'(1)) : (entry.age + AGE_W'(1));

endmodule

>>> design/bidirectional_typed_pointer_map.sv
// Bidirectional typed pointer map: sequencer, valid flags and response register.
// A search walks all slots through the shared compare unit, one slot per cycle
// from the RAM's single read port; a successful add or delete then runs a second pass
// over the whole table to renumber ages. One word is in work at a time.
// Reset clears the valid flags at once; the slot RAM itself is not cleared.
module bidirectional_typed_pointer_map
    import bdpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_WRITE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [SEQ_W-1:0]   cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               hit_reg, hit_next;
    slot_t              best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic             accept;
    logic             is_add, is_del, is_set, is_rev, is_lookup;
    logic             rd_issue;
    logic [IDX_W-1:0] rd_addr;
    logic [SLOT_W-1:0] rd_word;
    slot_t            rd_slot;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_slot;
    unit_res_t        unit_res;
    logic [AGE_W-1:0] age_next;
    logic             slot_live;
    logic             last;
    logic             take;
    logic             rsp_load;
    logic             ok_add, ok_look;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_add    = (req_reg.cmd == CMD_ADD);
    assign is_del    = (req_reg.cmd == CMD_DEL) || (req_reg.cmd == CMD_DEL_REV);
    assign is_set    = (req_reg.cmd == CMD_SET_CNT) || (req_reg.cmd == CMD_SET_CNT_REV);
    assign is_rev    = (req_reg.cmd == CMD_DEL_REV) || (req_reg.cmd == CMD_FIND_REV)
                    || (req_reg.cmd == CMD_GET_CNT_REV) || (req_reg.cmd == CMD_SET_CNT_REV);
    assign is_lookup = (req_reg.cmd >= CMD_DEL) && (req_reg.cmd <= CMD_SET_CNT_REV);

    // Both passes walk the table with the same read counter.
    assign rd_issue  = ((state_reg == S_SCAN) || (state_reg == S_SWEEP)) && (cnt_reg < SLOT_END);
    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign rd_slot   = slot_t'(rd_word);
    assign slot_live = valid_reg[rd_idx_reg];
    assign last      = rd_vld_reg && (rd_idx_reg == LAST_IDX);

    bdpm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (SLOT_W'(wr_slot)),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    bdpm_unit u_unit (
        .entry    (rd_slot),
        .reverse  (is_rev),
        .ptr      (is_rev ? req_reg.data_ptr : req_reg.key_ptr),
        .kind     (req_reg.entry_kind),
        .ref_age  (best_reg.age),
        .age_dec  (!is_add),
        .res      (unit_res),
        .age_next (age_next)
    );

    assign take = (state_reg == S_SCAN) && rd_vld_reg && slot_live && unit_res.match
               && (!hit_reg || unit_res.younger);

    assign ok_add  = is_add && free_found_reg;
    assign ok_look = is_lookup && hit_reg;

    always_comb
    begin
        rsp_next = rsp_reg;
        if (ok_add || ok_look)
        begin
            rsp_next.status = ST_OK;
        end
        else if (is_add)
        begin
            rsp_next.status = ST_FULL;
        end
        else
        begin
            rsp_next.status = ST_MISS;
        end
        rsp_next.found_key  = (ok_look && is_rev) ? best_reg.key : '0;
        rsp_next.found_data = (ok_look && !is_rev) ? best_reg.data : '0;
        if (ok_add)
        begin
            rsp_next.found_count = OCNT_W'(1);
        end
        else if (ok_look)
        begin
            rsp_next.found_count = {1'b0, (is_set ? req_reg.new_count : best_reg.count)};
        end
        else
        begin
            rsp_next.found_count = '1;
        end
    end

    assign rsp_load = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    // RAM write port: age renumbering in the second pass, the final slot update for add and set last.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_slot = rd_slot;
        priority if (state_reg == S_SWEEP)
        begin
            wr_en        = rd_vld_reg && slot_live && (is_add || unit_res.older);
            wr_slot.age  = age_next;
        end
        else if (state_reg == S_WRITE)
        begin
            if (is_add)
            begin
                wr_en         = 1'b1;
                wr_addr       = free_idx_reg;
                wr_slot.key   = req_reg.key_ptr;
                wr_slot.data  = req_reg.data_ptr;
                wr_slot.kind  = req_reg.entry_kind;
                wr_slot.count = CNT_W'(1);
                wr_slot.age   = '0;
            end
            else if (is_set)
            begin
                wr_en         = 1'b1;
                wr_addr       = best_idx_reg;
                wr_slot       = best_reg;
                wr_slot.count = req_reg.new_count;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = rd_issue;
        rd_idx_next     = rd_addr;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        if (rd_issue)
        begin
            cnt_next = cnt_reg + SEQ_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req;
                    cnt_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    hit_next      = 1'b1;
                    best_next     = rd_slot;
                    best_idx_next = rd_idx_reg;
                end
                if (rd_vld_reg && !slot_live && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
                if (last)
                begin
                    cnt_next = '0;
                    if (is_add)
                    begin
                        state_next = free_found_next ? S_SWEEP : S_RESP;
                    end
                    else if (is_lookup && hit_next)
                    begin
                        if (is_del)
                        begin
                            state_next = S_SWEEP;
                        end
                        else if (is_set)
                        begin
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (is_add)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                end
                else if (is_del)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            valid_reg      <= valid_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rd_idx_reg   <= rd_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        free_idx_reg <= free_idx_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // The renumbering pass only follows a successful search.
    a_sweep_has_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (is_add ? free_found_reg : hit_reg))
        else $error("age pass started without a free slot or a match");

    a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_reg) <= $countones($past(valid_reg)) + 1)
        && ($countones($past(valid_reg)) <= $countones(valid_reg) + 1))
        else $error("more than one slot changed occupancy in a cycle");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && (rsp_next.status == ST_FULL)) |-> (&valid_reg))
        else $error("table full reported with a free slot");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |->
        ((&rsp.found_count) && (rsp.found_key == '0) && (rsp.found_data == '0)))
        else $error("failed word carries a pointer or a count");

endmodule
